FILE: rtl/core/vrd_pkg.sv
// Shared constants, types and helpers for the VP9 RTP depacketizer.
`timescale 1ns / 1ps

package vrd_pkg;

  // Largest frame the reassembly can track, in bytes.
  localparam int unsigned MAX_FRAME_BYTES = 1048576;

  localparam int unsigned CNT_W = 21;
  localparam int unsigned OFF_W = 20;
  localparam int unsigned CFG_RESET = 1048576;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Capacity in force right after reset.
  localparam logic [CNT_W-1:0] CAP_RESET =
    CNT_W'((MAX_FRAME_BYTES < CFG_RESET) ? MAX_FRAME_BYTES : CFG_RESET);

  // Packet status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_PAYLOAD = 2'd1;
  localparam logic [1:0] ST_INVALID    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  // What the descriptor parser tells the frame tracker about the current byte.
  typedef struct packed {
    logic was_payload;     // byte belongs to the payload section
    logic ends_in_payload; // descriptor finished with this byte or earlier
    logic b_flag;          // start of frame flag of this packet
    logic e_flag;          // end of frame flag of this packet
  } desc_info_t;

  typedef struct packed {
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [OFF_W-1:0] frame_offset;
    logic             packet_done;
    logic [1:0]       status;
    logic             frame_complete;
    logic [CNT_W-1:0] frame_length;
  } result_t;

  // Clamp a written capacity to what the block can hold.
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CNT_W-1:0] value);
    if (32'(value) > MAX_FRAME_BYTES) begin
      clamp_cap = CNT_W'(MAX_FRAME_BYTES);
    end else begin
      clamp_cap = value;
    end
  endfunction

endpackage

FILE: rtl/core/vrd_desc_parser.sv
// Byte-serial walker over the VP9 payload descriptor.
`timescale 1ns / 1ps

module vrd_desc_parser
  import vrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output desc_info_t info
);

  localparam logic [3:0] PH_FIRST   = 4'd0;
  localparam logic [3:0] PH_PID1    = 4'd1;
  localparam logic [3:0] PH_PID2    = 4'd2;
  localparam logic [3:0] PH_LAYER   = 4'd3;
  localparam logic [3:0] PH_TL0     = 4'd4;
  localparam logic [3:0] PH_REF     = 4'd5;
  localparam logic [3:0] PH_SS      = 4'd6;
  localparam logic [3:0] PH_RES     = 4'd7;
  localparam logic [3:0] PH_GOFN    = 4'd8;
  localparam logic [3:0] PH_GOFD    = 4'd9;
  localparam logic [3:0] PH_GOFR    = 4'd10;
  localparam logic [3:0] PH_PAYLOAD = 4'd11;

  // Descriptor sections already finished when choosing the next one.
  localparam logic [2:0] SEC_HDR   = 3'd0;
  localparam logic [2:0] SEC_PID   = 3'd1;
  localparam logic [2:0] SEC_LAYER = 3'd2;
  localparam logic [2:0] SEC_REF   = 3'd3;
  localparam logic [2:0] SEC_SS    = 3'd4;

  // Flags: I=7 P=6 L=5 F=4 B=3 E=2 V=1.
  function automatic logic [3:0] next_section(input logic [7:0] f, input logic [2:0] done);
    if (done < SEC_PID && f[7]) begin
      next_section = PH_PID1;
    end else if (done < SEC_LAYER && f[5]) begin
      next_section = PH_LAYER;
    end else if (done < SEC_REF && f[4] && f[6]) begin
      next_section = PH_REF;
    end else if (done < SEC_SS && f[1]) begin
      next_section = PH_SS;
    end else begin
      next_section = PH_PAYLOAD;
    end
  endfunction

  logic [3:0] phase_r, phase_nxt, phase_step;
  logic [7:0] flags_r, flags_nxt;
  logic [1:0] ss_r, ss_nxt;
  logic [5:0] skip_r, skip_nxt;
  logic [7:0] gof_r, gof_nxt;
  logic [1:0] ref_r, ref_nxt;

  always_comb begin
    flags_nxt  = flags_r;
    ss_nxt     = ss_r;
    skip_nxt   = skip_r;
    gof_nxt    = gof_r;
    ref_nxt    = ref_r;
    phase_step = phase_r;
    case (phase_r)
      PH_PID1: begin
        phase_step = data_byte[7] ? PH_PID2 : next_section(flags_r, SEC_PID);
      end
      PH_PID2: begin
        phase_step = next_section(flags_r, SEC_PID);
      end
      PH_LAYER: begin
        phase_step = flags_r[4] ? next_section(flags_r, SEC_LAYER) : PH_TL0;
      end
      PH_TL0: begin
        phase_step = next_section(flags_r, SEC_LAYER);
      end
      PH_REF: begin
        if (!data_byte[0]) begin
          phase_step = next_section(flags_r, SEC_REF);
        end
      end
      PH_SS: begin
        // Y selects the resolution list, G the group-of-frames list.
        ss_nxt = {data_byte[4], data_byte[3]};
        if (data_byte[4]) begin
          skip_nxt   = {({1'b0, data_byte[7:5]} + 4'd1), 2'b00};
          phase_step = PH_RES;
        end else begin
          skip_nxt   = '0;
          phase_step = data_byte[3] ? PH_GOFN : PH_PAYLOAD;
        end
      end
      PH_RES: begin
        skip_nxt = skip_r - 6'd1;
        if (skip_nxt == '0) begin
          phase_step = ss_r[0] ? PH_GOFN : PH_PAYLOAD;
        end
      end
      PH_GOFN: begin
        gof_nxt    = data_byte;
        phase_step = (data_byte != '0) ? PH_GOFD : PH_PAYLOAD;
      end
      PH_GOFD: begin
        ref_nxt = data_byte[1:0];
        gof_nxt = gof_r - 8'd1;
        if (ref_nxt != '0) begin
          phase_step = PH_GOFR;
        end else begin
          phase_step = (gof_nxt != '0) ? PH_GOFD : PH_PAYLOAD;
        end
      end
      PH_GOFR: begin
        ref_nxt = ref_r - 2'd1;
        if (ref_nxt == '0) begin
          phase_step = (gof_r != '0) ? PH_GOFD : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        phase_step = PH_PAYLOAD;
      end
      default: begin
        flags_nxt  = data_byte;
        phase_step = next_section(data_byte, SEC_HDR);
      end
    endcase

    phase_nxt = phase_step;
    if (last_byte) begin
      phase_nxt = PH_FIRST;
      skip_nxt  = '0;
      gof_nxt   = '0;
      ref_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      flags_r <= '0;
      ss_r    <= '0;
      skip_r  <= '0;
      gof_r   <= '0;
      ref_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      ss_r    <= ss_nxt;
      skip_r  <= skip_nxt;
      gof_r   <= gof_nxt;
      ref_r   <= ref_nxt;
    end
  end

  assign info.was_payload     = (phase_r == PH_PAYLOAD);
  assign info.ends_in_payload = (phase_step == PH_PAYLOAD);
  assign info.b_flag          = flags_r[3];
  assign info.e_flag          = flags_r[2];

endmodule

FILE: rtl/core/vrd_frame_track.sv
// Payload byte counting, frame offsets and packet status.
`timescale 1ns / 1ps

module vrd_frame_track
  import vrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  desc_info_t       info,
  input  logic [CNT_W-1:0] cap,
  output logic             res_valid,
  output result_t          res
);

  logic [CNT_W-1:0] count_r, count_nxt, count_inc;
  logic [CNT_W-1:0] committed_r, committed_nxt;
  logic             started_r, started_nxt;
  logic [CNT_W-1:0] base;
  logic [CNT_W:0]   off;
  logic [CNT_W:0]   end_sum;
  logic             payload_step;
  logic             fwd;
  logic [1:0]       status;
  logic             done;

  always_comb begin
    payload_step = info.was_payload && (count_r != CNT_MAX);
    base         = info.b_flag ? '0 : committed_r;
    off          = {1'b0, base} + {1'b0, count_r};
    fwd          = payload_step && (info.b_flag || started_r) && (off < {1'b0, cap});
    count_inc    = count_r + CNT_W'(payload_step);
    end_sum      = {1'b0, base} + {1'b0, count_inc};

    committed_nxt = committed_r;
    started_nxt   = started_r;
    status        = ST_OK;
    done          = 1'b0;
    if (!info.was_payload) begin
      status = info.ends_in_payload ? ST_NO_PAYLOAD : ST_INVALID;
    end else if (!info.b_flag && !started_r) begin
      status = ST_INVALID;
    end else begin
      // A new frame restarts the length even when the packet overflows.
      if (info.b_flag) begin
        committed_nxt = '0;
        started_nxt   = 1'b1;
      end
      if (count_inc == CNT_MAX || end_sum > {1'b0, cap}) begin
        status = ST_OVERFLOW;
      end else begin
        committed_nxt = end_sum[CNT_W-1:0];
        if (info.e_flag) begin
          done        = 1'b1;
          started_nxt = 1'b0;
        end
      end
    end

    count_nxt = last_byte ? '0 : count_inc;

    res_valid          = fwd || last_byte;
    res.payload_valid  = fwd;
    res.payload_byte   = fwd ? data_byte : '0;
    res.frame_offset   = fwd ? off[OFF_W-1:0] : '0;
    res.packet_done    = last_byte;
    res.status         = last_byte ? status : ST_OK;
    res.frame_complete = last_byte && done;
    res.frame_length   = last_byte ? committed_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      committed_r <= '0;
      started_r   <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      if (last_byte) begin
        committed_r <= committed_nxt;
        started_r   <= started_nxt;
      end
    end
  end

endmodule

FILE: rtl/core/vp9_rtp_depacketizer_unit.sv
// Top level of the VP9 RTP depacketizer: descriptor parser, frame tracker, output register.
`timescale 1ns / 1ps

// Channel  Direction  Carries
// -------  ---------  ---------------------------------------------------------
// in_      slave      one payload byte per request, tlast on a packet's last byte
// out_     master     a forwarded frame byte and/or the packet status
// cfg_     slave      frame_capacity, always ready
//
// Each byte is parsed in the cycle it is accepted, its result is captured in the
// output register at the accepting edge and offered on out_ from the next cycle.
// A byte can be accepted every cycle; descriptor bytes that produce no result
// are simply absorbed. in_tready is low only while the output register holds a
// result that the sink is not taking in the same cycle. Reset (rst_n low,
// synchronous) returns the parser to the start of a descriptor and clears the
// frame state.
module vp9_rtp_depacketizer_unit
  import vrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] data_byte
  input  logic             in_tlast,   // last_byte

  output logic             out_tvalid,
  input  logic             out_tready,
  // [7:0] payload_byte, [27:8] frame_offset, [29:28] status,
  // [30] frame_complete, [51:31] frame_length, [55:52] zero
  output logic [55:0]      out_tdata,
  output logic             out_tuser,  // payload_valid
  output logic             out_tlast,  // packet_done

  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data    // frame_capacity
);

  logic             accept;
  logic [CNT_W-1:0] cap_r;
  desc_info_t       info;
  logic             res_valid;
  result_t          res;
  logic             out_valid_r;
  result_t          out_res_r;

  // The output register can take a new result when empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The capacity is clamped once when written, so the datapath sees the
  // value actually in force.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= clamp_cap(cfg_data);
    end
  end

  vrd_desc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .info      (info)
  );

  vrd_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .info      (info),
    .cap       (cap_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the output register needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.payload_valid;
  assign out_tlast  = out_res_r.packet_done;
  assign out_tdata  = {4'b0000,
                       out_res_r.frame_length,
                       out_res_r.frame_complete,
                       out_res_r.status,
                       out_res_r.frame_offset,
                       out_res_r.payload_byte};

endmodule
